[sv/rational_arith_unit_top_defines.svh]
// Assertion macros for the rational arithmetic unit.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef RATIONAL_ARITH_UNIT_TOP_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_TOP_DEFINES_SVH

// Same-cycle implication check
`define RAU_CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rau: same-cycle check failed");

// Next-cycle implication check
`define RAU_CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rau: next-cycle check failed");

`endif

[sv/rau_pkg.sv]
// Shared constants and types for the rational arithmetic unit.
// No dependencies; used by rau_div and rational_arith_unit_top.
package rau_pkg;

  localparam int DEF_OPERAND_WIDTH = 16;
  localparam int OPCODE_W          = 4;
  localparam int RES_NUM_W         = 33;
  localparam int RES_DEN_W         = 32;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_ADD = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_SUB = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_MUL = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_DIV = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_LT  = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_LE  = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_GT  = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_GE  = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_EQ  = 4'd8;
  localparam logic [OPCODE_W-1:0] OP_NE  = 4'd9;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/rau_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rau_pkg (div_stat_t).
module rau_div #(
  parameter int NW = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NW-1:0]     dividend,
  input  logic [NW-1:0]     divisor,
  output logic [NW-1:0]     quotient,
  output rau_pkg::div_stat_t stat
);
  import rau_pkg::*;

  localparam int CW = $clog2(NW);

  logic [NW-1:0] q_r, r_r, d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  // One restoring step: shift in next dividend bit, trial subtract
  logic [NW:0]   trial, diff;
  logic          ge;
  assign trial = {r_r, q_r[NW-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = !diff[NW];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(NW-1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW-1)) busy_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= {q_r[NW-2:0], ge};
      r_r <= ge ? diff[NW-1:0] : trial[NW-1:0];
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[sv/rational_arith_unit_top.sv]
// Rational arithmetic unit top level: serial multiply, binary gcd, serial divide.
// Depends on rau_pkg, rau_div and rational_arith_unit_top_defines.svh.
//
//   channel | direction | ports
//   in      | to block  | in_valid, in_stall, in_opcode, in_a_num, in_a_den, in_b_num, in_b_den
//   out     | from block| out_valid, out_stall, out_res_num, out_res_den, out_cmp_true, out_status
//
// One item at a time. Three shift-add products, then one combine state, which
// finishes comparisons. Arithmetic adds the binary gcd loop (shift and subtract
// steps, then one left shift per common factor of two restored) and two
// divisions in rau_div.
// Synchronous active-low reset returns to idle and empties the output register.
// The output register lets the next item in while a result waits there on out_stall.
`include "rational_arith_unit_top_defines.svh"

module rational_arith_unit_top #(
  parameter int OPERAND_WIDTH = rau_pkg::DEF_OPERAND_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rau_pkg::OPCODE_W-1:0]        in_opcode,
  input  logic signed [OPERAND_WIDTH-1:0]     in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]     in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]     in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]     in_b_den,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rau_pkg::RES_NUM_W-1:0] out_res_num,
  output logic signed [rau_pkg::RES_DEN_W-1:0] out_res_den,
  output logic                                out_cmp_true,
  output logic                                out_status
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int NW = 2 * W;
  localparam int SW = NW + 1;
  localparam int CW = $clog2(W);
  localparam int KW = $clog2(NW + 1);
  localparam int XW = (NW > RES_NUM_W) ? NW : RES_NUM_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_COMB = 9'b000001000,
    S_GCD  = 9'b000010000,
    S_GSHL = 9'b000100000,
    S_DIVN = 9'b001000000,
    S_DIVD = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [XW-1:0] to_bits(input logic neg, input logic [NW-1:0] mag);
    logic [XW-1:0] m;
    m = XW'(mag);
    return neg ? (~m + 1'b1) : m;
  endfunction

  state_t state_r, state_nxt;

  // Captured item, sign and magnitude
  logic [OPCODE_W-1:0] op_r;
  logic [W-1:0]        an_m_r, ad_m_r, bn_m_r, bd_m_r;
  logic                an_s_r, ad_s_r, bn_s_r, bd_s_r;

  // Serial multiplier
  logic [NW-1:0] acc_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    idx_r;
  logic [NW-1:0] prod_r [3];

  // Reduction
  logic [NW-1:0] num_mag_r, den_mag_r, x_r, y_r, nq_r;
  logic          sgn_r;
  logic [KW-1:0] k_r;

  // Result holding and output registers
  logic [RES_NUM_W-1:0] rnum_r;
  logic [RES_DEN_W-1:0] rden_r;
  logic                 rcmp_r, rstat_r;
  logic                 out_valid_r, out_cmp_r, out_stat_r;
  logic [RES_NUM_W-1:0] out_num_r;
  logic [RES_DEN_W-1:0] out_den_r;

  // Shared divider signals
  logic              div_start;
  logic [NW-1:0]     div_a, div_q;
  div_stat_t         div_stat;

  logic in_acc, out_load;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Opcode classes
  logic is_sub, is_mul, is_div, is_arith, is_cmp;
  always_comb begin
    is_sub   = (op_r == OP_SUB);
    is_mul   = (op_r == OP_MUL);
    is_div   = (op_r == OP_DIV);
    is_arith = op_r inside {[OP_ADD:OP_DIV]};
    is_cmp   = op_r inside {[OP_LT:OP_NE]};
  end

  // Operand pair for the current product
  logic [W-1:0] mcand, mplier;
  always_comb begin
    case (idx_r)
      2'd0: begin
        mcand  = an_m_r;
        mplier = is_mul ? bn_m_r : bd_m_r;
      end
      2'd1: begin
        mcand  = (is_mul || is_div) ? '0 : bn_m_r;
        mplier = ad_m_r;
      end
      default: begin
        mcand  = ad_m_r;
        mplier = is_div ? bn_m_r : bd_m_r;
      end
    endcase
  end

  // Shift-add step: add multiplicand to upper half, shift right
  logic [W:0]    mul_sum;
  logic [NW-1:0] acc_nxt;
  assign mul_sum = {1'b0, acc_r[NW-1:W]} + {1'b0, (acc_r[0] ? mcand : W'(0))};
  assign acc_nxt = {mul_sum, acc_r[W-1:1]};

  // Combine products: signed cross terms, sum, compare
  logic                 s0, s1, s2;
  logic signed [SW-1:0] p_val, q_val, sum_val;
  logic [SW-1:0]        neg_sum;
  logic                 num_neg, den_zero, den_neg;
  logic [NW-1:0]        num_mag, den_mag;
  logic                 p_lt, p_eq, flip, lt_eff, gt_eff, cmp_res;
  logic [XW-1:0]        unred_num_x, unred_den_x, fin_num_x, fin_den_x;
  always_comb begin
    s0      = an_s_r ^ (is_mul ? bn_s_r : bd_s_r);
    s1      = bn_s_r ^ ad_s_r;
    s2      = ad_s_r ^ (is_div ? bn_s_r : bd_s_r);
    p_val   = s0 ? -$signed({1'b0, prod_r[0]}) : $signed({1'b0, prod_r[0]});
    q_val   = s1 ? -$signed({1'b0, prod_r[1]}) : $signed({1'b0, prod_r[1]});
    sum_val = is_sub ? (p_val - q_val) : (p_val + q_val);
    neg_sum = -sum_val;
    num_neg = sum_val[SW-1];
    num_mag = num_neg ? neg_sum[NW-1:0] : sum_val[NW-1:0];
    den_mag = prod_r[2];
    den_zero = (den_mag == '0);
    den_neg  = s2 && !den_zero;
    // comparison; ordering flips unless the denominator product is positive
    p_lt   = (p_val < q_val);
    p_eq   = (p_val == q_val);
    flip   = den_zero || s2;
    lt_eff = flip ? (!p_lt && !p_eq) : p_lt;
    gt_eff = flip ? p_lt : (!p_lt && !p_eq);
    case (op_r)
      OP_LT:   cmp_res = lt_eff;
      OP_LE:   cmp_res = lt_eff || p_eq;
      OP_GT:   cmp_res = gt_eff;
      OP_GE:   cmp_res = gt_eff || p_eq;
      OP_EQ:   cmp_res = p_eq;
      OP_NE:   cmp_res = !p_eq;
      default: cmp_res = 1'b0;
    endcase
    unred_num_x = to_bits(num_neg, num_mag);
    unred_den_x = to_bits(den_neg, den_mag);
    fin_num_x   = to_bits(sgn_r, nq_r);
    fin_den_x   = XW'(div_q);
  end

  // Shared divider: numerator first, then denominator, both by the gcd
  assign div_start = ((state_r == S_GSHL) && (k_r == '0)) ||
                     ((state_r == S_DIVN) && div_stat.done);
  assign div_a     = (state_r == S_GSHL) ? num_mag_r : den_mag_r;

  rau_div #(.NW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (x_r),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_MUL;
      S_MUL: begin
        if (cnt_r == CW'(W-1)) state_nxt = (idx_r == 2'd2) ? S_COMB : S_LOAD;
      end
      S_COMB: begin
        if (is_arith && !den_zero && (num_mag != '0)) state_nxt = S_GCD;
        else state_nxt = S_DONE;
      end
      S_GCD:  if ((x_r == '0) || (y_r == '0)) state_nxt = S_GSHL;
      S_GSHL: if (k_r == '0) state_nxt = S_DIVN;
      S_DIVN: if (div_stat.done) state_nxt = S_DIVD;
      S_DIVD: if (div_stat.done) state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r   <= in_opcode;
          an_m_r <= mag_of(in_a_num);
          ad_m_r <= mag_of(in_a_den);
          bn_m_r <= mag_of(in_b_num);
          bd_m_r <= mag_of(in_b_den);
          an_s_r <= in_a_num[W-1];
          ad_s_r <= in_a_den[W-1];
          bn_s_r <= in_b_num[W-1];
          bd_s_r <= in_b_den[W-1];
          idx_r  <= 2'd0;
        end
      end
      S_LOAD: begin
        acc_r <= {W'(0), mplier};
        cnt_r <= '0;
      end
      S_MUL: begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W-1)) begin
          prod_r[idx_r] <= acc_nxt;
          idx_r         <= idx_r + 2'd1;
        end
      end
      S_COMB: begin
        rcmp_r  <= 1'b0;
        rstat_r <= 1'b0;
        rnum_r  <= '0;
        rden_r  <= '0;
        if (is_cmp) begin
          rcmp_r <= cmp_res;
        end else if (is_arith) begin
          if (den_zero) begin
            rstat_r <= 1'b1;
            rnum_r  <= unred_num_x[RES_NUM_W-1:0];
          end else if (num_mag == '0) begin
            rden_r <= unred_den_x[RES_DEN_W-1:0];
          end
        end
        num_mag_r <= num_mag;
        den_mag_r <= den_mag;
        sgn_r     <= num_neg ^ den_neg;
        x_r       <= num_mag;
        y_r       <= den_mag;
        k_r       <= '0;
      end
      // Binary gcd: strip common twos, halve an even operand, subtract odd from odd
      S_GCD: begin
        if (x_r == '0) begin
          x_r <= y_r;
        end else if (y_r == '0) begin
          x_r <= x_r;
        end else if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= x_r - y_r;
        end else begin
          y_r <= y_r - x_r;
        end
      end
      // Restore the common power of two, one bit a cycle
      S_GSHL: begin
        if (k_r != '0) begin
          x_r <= x_r << 1;
          k_r <= k_r - 1'b1;
        end
      end
      S_DIVN: if (div_stat.done) nq_r <= div_q;
      S_DIVD: begin
        if (div_stat.done) begin
          rnum_r <= fin_num_x[RES_NUM_W-1:0];
          rden_r <= fin_den_x[RES_DEN_W-1:0];
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_num_r <= rnum_r;
          out_den_r <= rden_r;
          out_cmp_r <= rcmp_r;
          out_stat_r <= rstat_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_res_num  = out_num_r;
  assign out_res_den  = out_den_r;
  assign out_cmp_true = out_cmp_r;
  assign out_status   = out_stat_r;

  // Checks
  `RAU_CHK_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `RAU_CHK_IMP(a_div_idle, state_r == S_IDLE, !div_stat.busy)
  `RAU_CHK_IMP(a_cmp_clean, out_valid && out_cmp_true,
               (out_res_num == '0) && (out_res_den == '0) && !out_status)
  `RAU_CHK_IMP(a_status_den, out_valid && out_status, out_res_den == '0)

endmodule
